/* hw/rtl/topological_sort_engine_assert.svh */
// Assertion macros used by the checker file.
`ifndef TOPOLOGICAL_SORT_ENGINE_ASSERT_SVH
`define TOPOLOGICAL_SORT_ENGINE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TSE_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define TSE_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

/* hw/rtl/tse_pkg.sv */
// Shared constants and types of the topological sort engine.
package tse_pkg;
  localparam int unsigned NodesDefault = 64;
  localparam int unsigned NodeW = 6;
  localparam int unsigned CountW = 7;
  localparam logic [1:0] ModeAdd = 2'd0;
  localparam logic [1:0] ModeRun = 2'd1;
  localparam logic [1:0] ModeClr = 2'd2;
  localparam logic [1:0] ModeNop = 2'd3;
  localparam logic [2:0] RegNodeCount = 3'd0;
  localparam logic [6:0] NodeCountReset = 7'd64;

  // Result item as it leaves the engine.
  typedef struct packed {
    logic       all_placed;
    logic       last;
    logic       node_valid;
    logic [5:0] node;
  } result_t;
endpackage

/* hw/rtl/tse_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
module tse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* hw/rtl/tse_core.sv */
// Sequencer of the sort: edge loads, clear sweep, in-degree count, queue walk.
module tse_core #(
  parameter int unsigned Nodes = tse_pkg::NodesDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [6:0]            node_count_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            mode_i,
  input  logic [5:0]            src_i,
  input  logic [5:0]            dst_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output tse_pkg::result_t      res_o
);
  import tse_pkg::*;
  localparam int unsigned AW = (Nodes > 1) ? $clog2(Nodes) : 1;
  localparam int unsigned CW = $clog2(Nodes + 1);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SAddRd = 4'd1;
  localparam logic [3:0] SAddWr = 4'd2;
  localparam logic [3:0] SClr = 4'd3;
  localparam logic [3:0] SZero = 4'd4;
  localparam logic [3:0] SCntRd = 4'd5;
  localparam logic [3:0] SCntDo = 4'd6;
  localparam logic [3:0] SScan = 4'd7;
  localparam logic [3:0] SPopRd = 4'd8;
  localparam logic [3:0] SPopWt = 4'd9;
  localparam logic [3:0] SEmit = 4'd10;
  localparam logic [3:0] SRowWt = 4'd11;
  localparam logic [3:0] SDec = 4'd12;
  localparam logic [3:0] SDecWr = 4'd13;
  localparam logic [3:0] SFin = 4'd14;

  logic [3:0] state_q, state_d;
  logic [AW-1:0] src_q, src_d, dcol_q, dcol_d, row_q, row_d;
  logic [5:0] dst_q, dst_d;
  logic [CW-1:0] n_q, n_d, head_q, head_d, tail_q, tail_d;
  logic [Nodes-1:0] row_bits_q, row_bits_d;
  logic [5:0] cur_q, cur_d;
  logic pend_q, pend_d;      // a node waits to be emitted
  logic [CW-1:0] emit_q, emit_d;

  // Adjacency RAM
  logic adj_we; logic [AW-1:0] adj_wa, adj_ra; logic [Nodes-1:0] adj_wd, adj_rd;
  tse_ram #(.Width(Nodes), .Depth(Nodes)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_wa), .wdata_i(adj_wd),
    .raddr_i(adj_ra), .rdata_o(adj_rd));
  // In-degree RAM
  logic deg_we; logic [AW-1:0] deg_wa, deg_ra; logic [CW-1:0] deg_wd, deg_rd;
  tse_ram #(.Width(CW), .Depth(Nodes)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(deg_wa), .wdata_i(deg_wd),
    .raddr_i(deg_ra), .rdata_o(deg_rd));
  // Ready queue RAM
  logic q_we; logic [AW-1:0] q_wa, q_ra; logic [AW-1:0] q_wd, q_rd;
  tse_ram #(.Width(AW), .Depth(Nodes)) u_q (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd),
    .raddr_i(q_ra), .rdata_o(q_rd));

  logic [CW-1:0] n_act;
  logic res_valid_q, res_valid_d;
  result_t res_q, res_d;
  logic out_free;
  logic [CW-1:0] dlast;

  always_comb begin
    if (node_count_i == 7'd0) n_act = CW'(1);
    else if (32'(node_count_i) > Nodes) n_act = CW'(Nodes);
    else n_act = CW'(node_count_i);
  end

  assign out_free = !res_valid_q || res_ready_i;
  assign in_ready_o = (state_q == SIdle);
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;
  assign dlast = n_q - CW'(1);

  always_comb begin
    state_d = state_q; src_d = src_q; dst_d = dst_q; dcol_d = dcol_q; row_d = row_q;
    n_d = n_q; head_d = head_q; tail_d = tail_q; row_bits_d = row_bits_q;
    cur_d = cur_q; pend_d = pend_q; emit_d = emit_q;
    res_valid_d = res_valid_q && !res_ready_i; res_d = res_q;
    adj_we = 1'b0; adj_wa = src_q; adj_wd = adj_rd | (Nodes'(1) << dst_q[AW-1:0]);
    adj_ra = src_q;
    deg_we = 1'b0; deg_wa = dcol_q; deg_wd = '0; deg_ra = dcol_q;
    q_we = 1'b0; q_wa = tail_q[AW-1:0]; q_wd = dcol_q; q_ra = head_q[AW-1:0];
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          src_d = src_i[AW-1:0]; dst_d = dst_i; dcol_d = '0; row_d = '0; n_d = n_act;
          case (mode_i)
            ModeAdd: begin
              if (32'(src_i) < Nodes && 32'(dst_i) < Nodes) state_d = SAddRd;
            end
            ModeRun: state_d = SZero;
            ModeClr: state_d = SClr;
            default: state_d = SIdle;
          endcase
        end
      end
      SAddRd: state_d = SAddWr;
      SAddWr: begin adj_we = 1'b1; state_d = SIdle; end
      SClr: begin
        adj_we = 1'b1; adj_wa = row_q; adj_wd = '0;
        row_d = row_q + AW'(1);
        if (32'(row_q) == Nodes - 1) state_d = SIdle;
      end
      // zero in-degrees
      SZero: begin
        deg_we = 1'b1; deg_wd = '0; dcol_d = dcol_q + AW'(1);
        if (CW'(dcol_q) == dlast) begin dcol_d = '0; row_d = '0; state_d = SCntRd; end
      end
      // fetch row, then add each column
      SCntRd: begin adj_ra = row_q; state_d = SCntDo; row_bits_d = '0; end
      SCntDo: begin
        if (row_bits_q == '0 && dcol_q == '0) row_bits_d = adj_rd;
        deg_ra = dcol_q;
        state_d = SDec;
        pend_d = 1'b0; // count pass
      end
      SDec: begin
        // in-degree of dcol_q is on deg_rd
        if (pend_q) begin
          if (row_bits_q[dcol_q] && deg_rd != '0) begin
            deg_we = 1'b1; deg_wd = deg_rd - CW'(1);
            if (deg_rd == CW'(1)) begin
              q_we = 1'b1; tail_d = tail_q + CW'(1);
            end
          end
        end else if (row_bits_q[dcol_q]) begin
          deg_we = 1'b1; deg_wd = deg_rd + CW'(1);
        end
        state_d = SDecWr;
      end
      SDecWr: begin
        // write lands this cycle; advance column
        if (CW'(dcol_q) == dlast) begin
          dcol_d = '0;
          if (pend_q) state_d = SPopRd;
          else if (CW'(row_q) == dlast) begin
            head_d = '0; tail_d = '0; emit_d = '0; state_d = SScan;
          end else begin
            row_d = row_q + AW'(1); state_d = SCntRd;
          end
        end else begin
          dcol_d = dcol_q + AW'(1); deg_ra = dcol_q + AW'(1); state_d = SDec;
        end
        if (state_d == SDec) deg_ra = dcol_q + AW'(1);
      end
      // queue every zero node; SScan reads each in-degree and SFin checks it
      SScan: begin
        deg_ra = dcol_q; state_d = SFin; pend_d = 1'b0;
      end
      SFin: begin
        if (!pend_q) begin
          if (deg_rd == '0) begin q_we = 1'b1; tail_d = tail_q + CW'(1); end
          if (CW'(dcol_q) == dlast) begin dcol_d = '0; state_d = SPopRd; end
          else begin dcol_d = dcol_q + AW'(1); state_d = SScan; end
        end
      end
      SPopRd: begin
        if (head_q == tail_q) begin
          if (out_free) begin
            res_valid_d = 1'b1; state_d = SIdle;
            if (emit_q == '0) begin
              res_d.node = '0; res_d.node_valid = 1'b0; res_d.last = 1'b1;
              res_d.all_placed = 1'b0;
            end else begin
              res_d.node = cur_q; res_d.node_valid = 1'b1; res_d.last = 1'b1;
              res_d.all_placed = (emit_q == n_q);
            end
          end
        end else begin
          q_ra = head_q[AW-1:0]; state_d = SPopWt;
        end
      end
      SPopWt: begin adj_ra = q_rd; row_d = q_rd; state_d = SRowWt; end
      // keep the popped node's row on the read port
      SRowWt: begin adj_ra = row_q; state_d = SEmit; end
      SEmit: begin
        adj_ra = row_q;
        // previous node goes out now that another follows it
        if (emit_q == '0 || out_free) begin
          if (emit_q != '0) begin
            res_valid_d = 1'b1; res_d.node = cur_q; res_d.node_valid = 1'b1;
            res_d.last = 1'b0; res_d.all_placed = 1'b0;
          end
          cur_d = 6'(row_q); emit_d = emit_q + CW'(1); head_d = head_q + CW'(1);
          row_bits_d = adj_rd; dcol_d = '0; deg_ra = '0; pend_d = 1'b1;
          state_d = SDec;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Control state; reset starts with a sweep that zeroes the adjacency rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr; res_valid_q <= 1'b0; pend_q <= 1'b0; row_q <= '0;
      head_q <= '0; tail_q <= '0; emit_q <= '0;
    end else begin
      state_q <= state_d; res_valid_q <= res_valid_d; pend_q <= pend_d; row_q <= row_d;
      head_q <= head_d; tail_q <= tail_d; emit_q <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d; dst_q <= dst_d; dcol_q <= dcol_d; n_q <= n_d;
    row_bits_q <= row_bits_d; cur_q <= cur_d; res_q <= res_d;
  end
endmodule

/* hw/rtl/topological_sort_engine.sv */
// An edge load reads and rewrites the source row with the edge bit set; a clear
// zeroes every adjacency row. A run zeroes the in-degree counts, counts them row
// by row, scans for zero in-degree nodes, emits them; output stalls hold it.
// Reset (rst_ni low, asynchronous) clears control state and sets node_count
// to 64, then a sweep zeroes the adjacency memory, requests held off.
// Throughput: one item at a time, set by the single-port memory walk.
module topological_sort_engine #(
  parameter int unsigned NODES = tse_pkg::NodesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // mode[1:0], src_node[7:2], dst_node[13:8]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // node[5:0], node_valid[6]
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o,  // all_placed
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tse_pkg::*;
  logic [6:0] node_count_q;
  result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr == RegNodeCount) ? {25'd0, node_count_q} : 32'd0;

  // node_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountReset;
    end else if (psel && penable && pwrite && paddr == RegNodeCount) begin
      node_count_q <= pwdata[6:0];
    end
  end

  tse_core #(.Nodes(NODES)) u_core (
    .clk_i, .rst_ni, .node_count_i(node_count_q),
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .mode_i(s_axis_tdata_i[1:0]), .src_i(s_axis_tdata_i[7:2]),
    .dst_i(s_axis_tdata_i[13:8]),
    .res_valid_o(m_axis_tvalid_o), .res_ready_i(m_axis_tready_i), .res_o(res));

  assign m_axis_tdata_o = {1'b0, res.node_valid, res.node};
  assign m_axis_tlast_o = res.last;
  assign m_axis_tuser_o = res.all_placed;
endmodule

/* hw/rtl/tse_checker.sv */
// Port-level checker for the topological sort engine, with its bind.
`include "topological_sort_engine_assert.svh"
module tse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic       m_axis_tuser_o
);
  `TSE_ASSERT_IMP(a_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
    1'b1 ##1 (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
  `TSE_ASSERT_IMP(a_placed_last, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o,
    m_axis_tlast_o && m_axis_tdata_o[6])
  `TSE_ASSERT_IMP(a_empty_last, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tdata_o[6],
    m_axis_tlast_o && m_axis_tdata_o[5:0] == 6'd0)
  `TSE_ASSERT_IMP(a_busy_run, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tlast_o,
    !s_axis_tready_o)
endmodule

bind topological_sort_engine tse_checker u_tse_checker (.*);

/* test/topological_sort_engine_test.sv */
// Self-checking testbench for the topological sort engine: edge, clear and run requests.
`timescale 1ns / 100ps

module topological_sort_engine_test;
  import tse_pkg::*;

  localparam int unsigned NumNodes = 64;
  localparam int unsigned CycleLimit = 10000000;
  localparam int unsigned SettleCycles = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // mode[1:0], src_node[7:2], dst_node[13:8]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // node[5:0], node_valid[6]
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;   // all_placed
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  topological_sort_engine #(.NODES(NumNodes)) u_dut (.*);

  // Predictor state
  logic [63:0] graph_rows [NumNodes];
  logic [6:0]  used_nodes;
  result_t     order_q [$];
  logic [15:0] request_q [$];
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned recv_gap;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Append one request to the pending list
  task automatic queue_request(input logic [15:0] req);
    request_q = {request_q, req};
  endtask

  // Expected order for one run, following Kahn's algorithm in ascending label order
  task automatic predict_run();
    int unsigned n;
    int unsigned deg [NumNodes];
    logic [5:0]  ready [$];
    int unsigned placed;
    logic [5:0]  v;
    result_t     r;
    n = (used_nodes == 0) ? 1 : ((used_nodes > NumNodes) ? NumNodes : used_nodes);
    placed = 0;
    for (int d = 0; d < n; d++) begin
      deg[d] = 0;
      for (int s = 0; s < n; s++) if (graph_rows[s][d]) deg[d]++;
    end
    for (int d = 0; d < n; d++) if (deg[d] == 0) ready = {ready, 6'(d)};
    while (ready.size() > 0) begin
      v = ready.pop_front();
      r = '0;
      r.node = v;
      r.node_valid = 1'b1;
      order_q = {order_q, r};
      placed++;
      for (int d = 0; d < n; d++) begin
        if (graph_rows[v][d] && deg[d] != 0) begin
          deg[d]--;
          if (deg[d] == 0) ready = {ready, 6'(d)};
        end
      end
    end
    if (placed == 0) begin
      r = '0;
      r.last = 1'b1;
      order_q = {order_q, r};
    end else begin
      order_q[$].last = 1'b1;
      order_q[$].all_placed = (placed == n);
    end
  endtask

  task automatic apply_request(input logic [15:0] req);
    case (req[1:0])
      ModeAdd: graph_rows[req[7:2]][req[13:8]] = 1'b1;
      ModeRun: predict_run();
      ModeClr: for (int s = 0; s < NumNodes; s++) graph_rows[s] = '0;
      default: ;
    endcase
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      send_gap        <= 0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      apply_request(s_axis_tdata_i);
      if ($urandom_range(0, 2) == 0 && request_q.size() > 0) begin
        s_axis_tdata_i <= request_q.pop_front();
      end else begin
        s_axis_tvalid_i <= 1'b0;
        send_gap        <= $urandom_range(0, 16);
      end
    end else if (!s_axis_tvalid_i) begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (request_q.size() > 0) begin
        s_axis_tdata_i  <= request_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_gap        <= 0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (order_q.size() == 0) begin
        $error("unexpected result node=%0d", m_axis_tdata_o[5:0]);
        err_count++;
      end else begin
        result_t e;
        e = order_q.pop_front();
        if (m_axis_tdata_o[5:0] !== e.node) begin
          $error("node: expected %0d, got %0d", e.node, m_axis_tdata_o[5:0]);
          err_count++;
        end
        if (m_axis_tdata_o[6] !== e.node_valid) begin
          $error("node_valid: expected %0b, got %0b", e.node_valid, m_axis_tdata_o[6]);
          err_count++;
        end
        if (m_axis_tlast_o !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, m_axis_tlast_o);
          err_count++;
        end
        if (m_axis_tuser_o !== e.all_placed) begin
          $error("all_placed: expected %0b, got %0b", e.all_placed, m_axis_tuser_o);
          err_count++;
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        m_axis_tready_i <= 1'b0;
        recv_gap        <= $urandom_range(0, 16);
      end
    end else if (!m_axis_tready_i) begin
      if (recv_gap > 0) recv_gap <= recv_gap - 1;
      else m_axis_tready_i <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("topological_sort_engine_test failed");
      $finish;
    end
  end

  function automatic logic [15:0] pack_req(logic [1:0] mode, int unsigned src, int unsigned dst);
    return {2'b00, 6'(dst), 6'(src), mode};
  endfunction

  // Block until every request is accepted and every result has come, then let the engine settle
  task automatic drain();
    while (request_q.size() > 0 || s_axis_tvalid_i || order_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [6:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(RegNodeCount) << 2;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    used_nodes = value;
  endtask

  // Mostly acyclic edges inside the active range, with some noise and broken graphs
  task automatic random_phase(input int unsigned edges);
    int unsigned n;
    int unsigned s;
    n = (used_nodes == 0) ? 1 : ((used_nodes > NumNodes) ? NumNodes : used_nodes);
    queue_request(pack_req(ModeClr, $urandom_range(0, 63), $urandom_range(0, 63)));
    for (int i = 0; i < edges; i++) begin
      case ($urandom_range(0, 9))
        0: queue_request(pack_req(ModeAdd, $urandom_range(0, 63), $urandom_range(0, 63)));
        1: queue_request(pack_req(ModeAdd, $urandom_range(0, n - 1),
                                  $urandom_range(0, n - 1)));
        2: queue_request(pack_req(ModeNop, $urandom_range(0, 63), $urandom_range(0, 63)));
        default: begin
          if (n >= 2) begin
            s = $urandom_range(0, n - 2);
            queue_request(pack_req(ModeAdd, s, $urandom_range(s + 1, n - 1)));
          end else begin
            queue_request(pack_req(ModeAdd, 0, $urandom_range(1, 63)));
          end
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) queue_request(pack_req(ModeRun, 0, 0));
    queue_request(pack_req(ModeRun, $urandom_range(0, 63), $urandom_range(0, 63)));
  endtask

  initial begin
    logic [6:0] nc;
    int unsigned sent;
    err_count   = 0;
    cycle_count = 0;
    used_nodes  = NodeCountReset;
    for (int s = 0; s < NumNodes; s++) graph_rows[s] = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: full-size graph, extreme labels, duplicates, self loop, unused mode
    queue_request(pack_req(ModeClr, 0, 0));
    queue_request(pack_req(ModeRun, 0, 0));
    queue_request(pack_req(ModeAdd, 63, 0));
    queue_request(pack_req(ModeAdd, 63, 0));
    queue_request(pack_req(ModeAdd, 0, 63));
    queue_request(pack_req(ModeRun, 63, 63));
    queue_request(pack_req(ModeClr, 63, 63));
    queue_request(pack_req(ModeAdd, 5, 5));
    queue_request(pack_req(ModeNop, 1, 2));
    queue_request(pack_req(ModeAdd, 1, 2));
    queue_request(pack_req(ModeRun, 0, 0));
    drain();
    // Single node, with and without a self loop
    write_node_count(7'd1);
    queue_request(pack_req(ModeClr, 0, 0));
    queue_request(pack_req(ModeAdd, 0, 40));
    queue_request(pack_req(ModeRun, 0, 0));
    queue_request(pack_req(ModeAdd, 0, 0));
    queue_request(pack_req(ModeRun, 0, 0));
    drain();
    // Zero is taken as one; two-node cycle gives nothing placed
    write_node_count(7'd0);
    queue_request(pack_req(ModeRun, 0, 0));
    drain();
    write_node_count(7'd2);
    queue_request(pack_req(ModeClr, 0, 0));
    queue_request(pack_req(ModeAdd, 0, 1));
    queue_request(pack_req(ModeAdd, 1, 0));
    queue_request(pack_req(ModeRun, 0, 0));
    drain();
    // Above the node limit saturates
    write_node_count(7'd127);
    queue_request(pack_req(ModeAdd, 42, 21));
    queue_request(pack_req(ModeRun, 0, 0));
    drain();

    // Random phases, each with its own node count
    sent = 0;
    while (sent < 350) begin
      case ($urandom_range(0, 19))
        0:       nc = 7'($urandom_range(64, 127));
        1:       nc = 7'd0;
        2, 3, 4: nc = 7'($urandom_range(11, 24));
        default: nc = 7'($urandom_range(1, 10));
      endcase
      write_node_count(nc);
      nc = 7'($urandom_range(4, 24));
      random_phase(nc);
      sent += nc + 2;
      drain();
    end

    drain();
    if (err_count == 0) begin
      $display("topological_sort_engine_test passed");
    end else begin
      $display("topological_sort_engine_test failed");
    end
    $finish;
  end
endmodule
